@@ design/stdf_pkg.sv @@
package stdf_pkg;

  // parameter defaults
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned INDEX_WIDTH_DEF  = 32;
  localparam int unsigned SYNC_SPACING_DEF = 8;

  // field and register widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned PER_W      = 20;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned START_W    = 32;
  localparam int unsigned CODE_W     = 64;
  localparam int unsigned RESULT_W   = START_W + CODE_W;
  localparam int unsigned SINCE_W    = 32;
  localparam int unsigned OFFSET_W   = 32;

  // bit time arithmetic: coefficient 2*keff+3 fits 8 bits for any sync spacing >= 2
  localparam int unsigned COEF_W  = 8;
  localparam int unsigned PROD_W  = COEF_W + PER_W;
  localparam int unsigned NOFF_W  = PROD_W - 1;
  localparam int unsigned GAP_W   = PER_W + 5;
  localparam int unsigned GAPCMP_W = SINCE_W + 9;
  // position within a sync group, holds a spacing up to 64
  localparam int unsigned PHASE_W = 6;

  localparam logic [CNT_W-1:0] MAX_BITS = 7'd64;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_PERIOD      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_BITS      = 2'd2;

  // register reset values
  localparam logic [THR_W-1:0] THR_RESET = 16'd128;
  localparam logic [PER_W-1:0] PER_RESET = 20'd6400;
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd35;

  typedef enum logic [1:0] {
    ST_STREAM  = 2'b01,
    ST_CATCHUP = 2'b10
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [START_W-1:0] start;
  } result_t;

endpackage

@@ design/sampled_timecode_deframer.sv @@
// channel   | dir | handshake                    | payload (low bit first)
// ----------+-----+------------------------------+---------------------------------------
// s_axis    | in  | s_axis_tvalid_i/tready_o     | tdata: sample_value[15:0]
// m_axis    | out | m_axis_tvalid_o/tready_i     | tdata: frame_start_index[31:0],
//           |     |                              |        frame_code[95:32]
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_addr_i register, cfg_wdata_i value
//
// one sample is taken every cycle; edge tracking, frame open and bit slicing for
// that sample happen between the input handshake and the result queue in one pass
// the slicer takes one bit per cycle; a sample on which n > 1 bits fall (bit period
// below one sample, or changed mid-frame) holds the input while catch-up takes the rest
// results go to a two entry queue; input and catch-up stall while both entries wait
// reset clears all tracking state and loads register defaults, no clearing pass
module sampled_timecode_deframer
  import stdf_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned INDEX_WIDTH  = INDEX_WIDTH_DEF,
  parameter int unsigned SYNC_SPACING = SYNC_SPACING_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,   // sample_value
  // frame results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [RESULT_W-1:0]   m_axis_tdata_o,   // frame_start_index, frame_code
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  logic [THR_W-1:0] thr_q;
  logic [PER_W-1:0] per_q;
  logic [CNT_W-1:0] frame_bits_q;

  // edge tracking
  logic [INDEX_WIDTH-1:0] pos_q;
  logic                   prev_lvl_q;
  logic [SINCE_W-1:0]     since_q;

  // frame state
  state_e              st_q;
  logic                hold_lvl_q;
  logic                in_frame_q;
  logic [CNT_W-1:0]    bits_q;
  logic [COEF_W-1:0]   keff_q;
  logic [PHASE_W-1:0]  phase_q;
  logic [NOFF_W-1:0]   noff_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [CODE_W-1:0]   code_q;
  logic [START_W-1:0]  origin_q;

  // result queue
  logic [1:0] q_cnt_q;
  result_t    slot0_q, slot1_q;
  logic       q_full, push, pop;

  // combinational
  logic                s_acc, step;
  logic                lvl_in, lvl, edge_det, gap, open_frame;
  logic [GAP_W-1:0]    gap_lim;
  logic [CNT_W-1:0]    cnt;
  logic                fr0, full0, due0, take, full1, due1, emit, more, fr_after;
  logic [CNT_W-1:0]    b0, b1;
  logic [NOFF_W-1:0]   nf0, nf1, nf_first;
  logic [CODE_W-1:0]   code0, code1;
  logic [OFFSET_W-1:0] off0, off_next;
  logic [START_W-1:0]  org0;
  logic [COEF_W-1:0]   keff0, keff1, coef1;
  logic [PHASE_W-1:0]  ph0, ph1;
  logic                sync_next;
  logic [PROD_W-1:0]   prod1;
  result_t             new_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q        <= THR_RESET;
      per_q        <= PER_RESET;
      frame_bits_q <= CNT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_LEVEL_THRESHOLD: thr_q        <= cfg_wdata_i[THR_W-1:0];
        REG_BIT_PERIOD:      per_q        <= cfg_wdata_i[PER_W-1:0];
        REG_FRAME_BITS:      frame_bits_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // handshake and step control
  assign q_full          = (q_cnt_q == 2'd2);
  assign s_axis_tready_o = (st_q == ST_STREAM) && !q_full;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  // a catch-up cycle may emit, so it waits for room in the queue as well
  assign step            = s_acc || ((st_q == ST_CATCHUP) && !q_full);

  // slicer: only the low SAMPLE_WIDTH bits of the sample count
  assign lvl_in = 16'(s_axis_tdata_i[SAMPLE_WIDTH-1:0]) > thr_q;
  assign lvl    = (st_q == ST_CATCHUP) ? hold_lvl_q : lvl_in;

  // gap test: since * 512 >= 19 * bit period, exact
  assign gap_lim    = GAP_W'(per_q) * GAP_W'(19);
  assign edge_det   = (lvl_in != prev_lvl_q);
  assign gap        = {since_q, 9'b0} >= GAPCMP_W'(gap_lim);
  assign open_frame = s_acc && edge_det && gap && !in_frame_q;

  // first bit sits 1.5 bit periods after the opening edge
  assign nf_first = NOFF_W'((PROD_W'(per_q) * PROD_W'(3)) >> 1);

  // frame state as seen after a possible open on this sample
  assign fr0   = in_frame_q || open_frame;
  assign b0    = open_frame ? '0 : bits_q;
  assign keff0 = open_frame ? '0 : keff_q;
  assign ph0   = open_frame ? '0 : phase_q;
  assign nf0   = open_frame ? nf_first : noff_q;
  assign code0 = open_frame ? '0 : code_q;
  assign off0  = open_frame ? '0 : offset_q;
  assign org0  = open_frame ? START_W'(pos_q) : origin_q;

  assign cnt = (frame_bits_q > MAX_BITS) ? MAX_BITS : frame_bits_q;

  // this bit
  assign full0 = (b0 >= cnt);
  assign due0  = OFFSET_W'(nf0[NOFF_W-1:8]) <= off0;
  assign take  = fr0 && !full0 && due0;

  // the bit after it; keff steps over a sync position after every SYNC_SPACING bits
  assign sync_next = (ph0 == PHASE_W'(SYNC_SPACING - 1));
  assign ph1       = sync_next ? '0 : ph0 + PHASE_W'(1);
  assign b1        = b0 + 7'd1;
  assign keff1     = keff0 + (sync_next ? COEF_W'(2) : COEF_W'(1));
  assign coef1     = {keff1[COEF_W-2:0], 1'b0} + COEF_W'(3);
  assign prod1     = PROD_W'(coef1) * PROD_W'(per_q);
  assign nf1       = prod1[PROD_W-1:1];
  assign code1     = {code0[CODE_W-2:0], lvl};
  assign full1     = (b1 >= cnt);
  assign due1      = OFFSET_W'(nf1[NOFF_W-1:8]) <= off0;

  // emit when the count is reached before or right after this bit
  assign emit     = fr0 && (full0 || (take && full1));
  // another bit due on the same sample: finish it in a catch-up cycle
  assign more     = take && !full1 && due1;
  assign fr_after = fr0 && !emit;
  assign off_next = (fr_after && !more && (off0 != '1)) ? off0 + 32'd1 : off0;

  assign new_res.start = org0;
  assign new_res.code  = full0 ? code0 : code1;

  // edge tracking, once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_lvl_q <= 1'b0;
      since_q    <= '0;
    end else if (s_acc) begin
      pos_q      <= pos_q + INDEX_WIDTH'(1);
      prev_lvl_q <= lvl_in;
      if (edge_det) begin
        since_q <= SINCE_W'(1);
      end else if (since_q != '1) begin
        since_q <= since_q + SINCE_W'(1);
      end
    end
  end

  // frame state, once per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_STREAM;
      hold_lvl_q <= 1'b0;
      in_frame_q <= 1'b0;
      bits_q     <= '0;
      keff_q     <= '0;
      phase_q    <= '0;
      noff_q     <= '0;
      offset_q   <= '0;
      code_q     <= '0;
      origin_q   <= '0;
    end else if (step) begin
      st_q       <= more ? ST_CATCHUP : ST_STREAM;
      hold_lvl_q <= lvl;
      in_frame_q <= fr_after;
      bits_q     <= take ? b1 : b0;
      keff_q     <= take ? keff1 : keff0;
      phase_q    <= take ? ph1 : ph0;
      noff_q     <= take ? nf1 : nf0;
      code_q     <= take ? code1 : code0;
      offset_q   <= off_next;
      origin_q   <= org0;
    end
  end

  // two entry result queue, slot0 is the head
  assign push = step && emit;
  assign pop  = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q <= '0;
    end else if (push && !pop) begin
      q_cnt_q <= q_cnt_q + 2'd1;
    end else if (pop && !push) begin
      q_cnt_q <= q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      slot0_q <= new_res;
    end else if (push) begin
      if (q_cnt_q == 2'd0) begin
        slot0_q <= new_res;
      end else begin
        slot1_q <= new_res;
      end
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign m_axis_tvalid_o = (q_cnt_q != 2'd0);
  assign m_axis_tdata_o  = slot0_q;

`ifndef SYNTHESIS
  // a request never lands in a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("result queue overflow");

  // catch-up only continues an open frame
  assert property (@(posedge clk_i) disable iff (!rst_ni) (st_q == ST_CATCHUP) |-> in_frame_q)
    else $error("catch-up outside a frame");

  // bit counter never passes the saturated frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni) bits_q <= MAX_BITS)
    else $error("bit counter out of range");

  // an emitted frame is closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> !in_frame_q)
    else $error("frame still open after emit");
`endif

endmodule
